@@ rtl/assert_macros.svh @@
// Assertion macros used by the pulse segment generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/psg_pkg.sv @@
// Types, constants and microcode table of the pulse segment generator.
package psg_pkg;

    localparam int V_W     = 10;
    localparam int DUR_W   = 16;
    localparam int STEP_W  = 5;
    localparam int LEVEL_W = 18;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLING = 2'd2;

    localparam logic KIND_RW       = 1'b0;
    localparam logic KIND_SAMPLING = 1'b1;

    // Micro-operations of one control word.
    typedef enum logic [2:0] {
        UOP_WAIT_IN,   // wait for an input item
        UOP_DIV_LOAD,  // load the serial divider
        UOP_DIV_RUN,   // one quotient bit per cycle until done
        UOP_HOLD,      // one fixed window, skipped when its segment is absent
        UOP_RAMP       // ramp windows, one per cycle while the output is not stalled
    } t_uop;

    // Window segments, in emission order.
    typedef enum logic [2:0] {
        SEG_PRE  = 3'd0,
        SEG_RISE = 3'd1,
        SEG_WAIT = 3'd2,
        SEG_PLAT = 3'd3,
        SEG_STOP = 3'd4,
        SEG_FALL = 3'd5,
        SEG_POST = 3'd6,
        SEG_NONE = 3'd7
    } t_seg;

    localparam int NUM_SEG = 7;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDIV_LD,
        ST_RDIV,
        ST_FDIV_LD,
        ST_FDIV,
        ST_PRE,
        ST_RISE,
        ST_WAIT,
        ST_PLAT,
        ST_STOP,
        ST_FALL,
        ST_POST
    } t_step;

    typedef struct packed {
        t_uop  op;
        t_seg  seg;
        t_step next;
    } t_uword;

    // Control store.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_IDLE:    w = '{UOP_WAIT_IN,  SEG_NONE, ST_RDIV_LD};
            ST_RDIV_LD: w = '{UOP_DIV_LOAD, SEG_RISE, ST_RDIV};
            ST_RDIV:    w = '{UOP_DIV_RUN,  SEG_RISE, ST_FDIV_LD};
            ST_FDIV_LD: w = '{UOP_DIV_LOAD, SEG_FALL, ST_FDIV};
            ST_FDIV:    w = '{UOP_DIV_RUN,  SEG_FALL, ST_PRE};
            ST_PRE:     w = '{UOP_HOLD,     SEG_PRE,  ST_RISE};
            ST_RISE:    w = '{UOP_RAMP,     SEG_RISE, ST_WAIT};
            ST_WAIT:    w = '{UOP_HOLD,     SEG_WAIT, ST_PLAT};
            ST_PLAT:    w = '{UOP_HOLD,     SEG_PLAT, ST_STOP};
            ST_STOP:    w = '{UOP_HOLD,     SEG_STOP, ST_FALL};
            ST_FALL:    w = '{UOP_RAMP,     SEG_FALL, ST_POST};
            ST_POST:    w = '{UOP_HOLD,     SEG_POST, ST_IDLE};
            default:    w = '{UOP_WAIT_IN,  SEG_NONE, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/pulse_segment_generator_core.sv @@
// Pulse segment generator: microcoded sequencer that turns one pulse into its windows.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   pulse   | in        | i_in_valid / o_in_ready    | i_kind .. i_measure_mode
//   window  | out       | o_out_valid / i_out_ready  | o_level, o_duration_us,
//           |           |                            | o_window_measure, o_last
//
// One pulse occupies the sequencer from accept to ready again, with saturated step
// counts for rise and fall, and longer while the window channel stalls. The two
// serial ramp divisions (one quotient bit per cycle, 10 + FRACTION_BITS bits each)
// and the one-window-per-cycle emit steps, held while the output stalls, set this.
// A new pulse is taken only in the idle step; the last window may still sit in the
// output register then. Synchronous active-low reset returns the step counter to
// idle and empties the output register. A stalled output freezes the sequencer at
// its next window step.
module pulse_segment_generator_core #(
    parameter int MAX_RAMP_STEPS = 28,
    parameter int FRACTION_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [psg_pkg::V_W-1:0]          i_v_low,
    input  logic [psg_pkg::V_W-1:0]          i_v_high,
    input  logic [psg_pkg::DUR_W-1:0]        i_pre_hold_us,
    input  logic [psg_pkg::DUR_W-1:0]        i_post_hold_us,
    input  logic [psg_pkg::STEP_W-1:0]       i_rise_steps,
    input  logic [psg_pkg::STEP_W-1:0]       i_fall_steps,
    input  logic [psg_pkg::DUR_W-1:0]        i_plateau_us,
    input  logic [psg_pkg::DUR_W-1:0]        i_wait_us,
    input  logic [psg_pkg::DUR_W-1:0]        i_stop_us,
    input  logic [psg_pkg::MODE_W-1:0]       i_measure_mode,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [psg_pkg::LEVEL_W-1:0]      o_level,
    output logic [psg_pkg::DUR_W-1:0]        o_duration_us,
    output logic [psg_pkg::MODE_W-1:0]       o_window_measure,
    output logic                             o_last
);

    // Magnitude width of a scaled level, and signed width of levels and deltas.
    localparam int MW  = psg_pkg::V_W + FRACTION_BITS;
    localparam int AW  = MW + 1;
    localparam int CW  = $clog2(MW + 1);
    localparam int SW  = psg_pkg::STEP_W;

    localparam logic [SW-1:0] MAX_STEPS = SW'(MAX_RAMP_STEPS);

    // ------------------------------------------------------------------
    // Latched pulse description
    // ------------------------------------------------------------------
    logic                         r_kind;
    logic [psg_pkg::V_W-1:0]      r_vlo, r_vhi;
    logic [psg_pkg::DUR_W-1:0]    r_pre, r_post, r_plat, r_wait, r_stop;
    logic [SW-1:0]                r_rise, r_fall;
    logic [psg_pkg::MODE_W-1:0]   r_mmode;

    // Sequencer and datapath registers
    psg_pkg::t_step               r_step, n_step;
    logic [SW-1:0]                r_cnt;
    logic [CW-1:0]                r_div_cnt;
    logic [SW-1:0]                r_div;
    logic [SW-1:0]                r_rem;
    logic [MW-1:0]                r_quo;
    logic signed [AW-1:0]         r_rdelta, r_fdelta;
    logic signed [AW-1:0]         r_lvl;

    // Output register
    logic                         r_out_valid;
    logic [psg_pkg::LEVEL_W-1:0]  r_level;
    logic [psg_pkg::DUR_W-1:0]    r_dur;
    logic [psg_pkg::MODE_W-1:0]   r_meas;
    logic                         r_last;

    psg_pkg::t_uword              uw;
    logic                         in_acc;
    logic                         out_can;

    assign uw      = psg_pkg::ucode(r_step);
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_can = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Level arithmetic
    // ------------------------------------------------------------------
    logic signed [AW-1:0] lo_s, hi_s, diff;
    logic [MW-1:0]        mag;
    logic                 neg;

    assign lo_s = AW'(MW'(r_vlo) << FRACTION_BITS);
    assign hi_s = AW'(MW'(r_vhi) << FRACTION_BITS);
    assign diff = hi_s - lo_s;
    assign neg  = diff[AW-1];
    assign mag  = neg ? MW'(-diff) : MW'(diff);

    // Restoring divider step
    logic [SW:0]          rem_sh;
    logic                 q_bit;
    logic [SW:0]          rem_sub;
    logic [MW-1:0]        quo_n;
    logic signed [AW-1:0] q_s;

    assign rem_sh  = {r_rem, r_quo[MW-1]};
    assign q_bit   = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign quo_n   = {r_quo[MW-2:0], q_bit};
    assign q_s     = AW'(quo_n);

    // ------------------------------------------------------------------
    // Segment presence and last-window detection
    // ------------------------------------------------------------------
    logic                    sampling;
    logic [psg_pkg::NUM_SEG-1:0] seg_en;
    logic                    later;
    logic [SW-1:0]           ramp_steps;
    logic                    ramp_end;

    assign sampling = (r_kind == psg_pkg::KIND_SAMPLING);

    always_comb begin
        seg_en                 = '0;
        seg_en[psg_pkg::SEG_PRE]  = (r_pre  != '0);
        seg_en[psg_pkg::SEG_RISE] = (r_rise != '0);
        seg_en[psg_pkg::SEG_WAIT] = !sampling && (r_wait != '0);
        seg_en[psg_pkg::SEG_PLAT] = (r_plat != '0);
        seg_en[psg_pkg::SEG_STOP] = !sampling && (r_stop != '0);
        seg_en[psg_pkg::SEG_FALL] = (r_fall != '0);
        seg_en[psg_pkg::SEG_POST] = (r_post != '0);
    end

    always_comb begin
        later = 1'b0;
        for (int j = 0; j < psg_pkg::NUM_SEG; j++) begin
            if (j > int'(uw.seg)) later = later | seg_en[j];
        end
    end

    assign ramp_steps = (uw.seg == psg_pkg::SEG_RISE) ? r_rise : r_fall;
    assign ramp_end   = (r_cnt == ramp_steps);

    // Fixed-window payload
    logic                       hold_en;
    logic [psg_pkg::DUR_W-1:0]  hold_dur;
    logic signed [AW-1:0]       hold_lvl;
    logic [psg_pkg::MODE_W-1:0] tag;
    logic [psg_pkg::MODE_W-1:0] hold_meas;

    assign tag = sampling ? psg_pkg::MODE_SAMPLING : psg_pkg::MODE_NONE;

    always_comb begin
        hold_en   = 1'b0;
        hold_dur  = r_pre;
        hold_lvl  = lo_s;
        hold_meas = tag;
        unique case (uw.seg)
            psg_pkg::SEG_PRE: begin
                hold_en  = seg_en[psg_pkg::SEG_PRE];
                hold_dur = r_pre;
            end
            psg_pkg::SEG_WAIT: begin
                hold_en   = seg_en[psg_pkg::SEG_WAIT];
                hold_dur  = r_wait;
                hold_lvl  = hi_s;
                hold_meas = psg_pkg::MODE_NONE;
            end
            psg_pkg::SEG_PLAT: begin
                hold_en   = seg_en[psg_pkg::SEG_PLAT];
                hold_dur  = r_plat;
                hold_lvl  = hi_s;
                hold_meas = sampling ? psg_pkg::MODE_SAMPLING : r_mmode;
            end
            psg_pkg::SEG_STOP: begin
                hold_en   = seg_en[psg_pkg::SEG_STOP];
                hold_dur  = r_stop;
                hold_lvl  = hi_s;
                hold_meas = psg_pkg::MODE_NONE;
            end
            psg_pkg::SEG_POST: begin
                hold_en  = seg_en[psg_pkg::SEG_POST];
                hold_dur = r_post;
            end
            default: begin
                hold_en = 1'b0;
            end
        endcase
    end

    // Ramp payload: next level from the segment base or the running level
    logic signed [AW-1:0]        ramp_cur, ramp_nxt;
    assign ramp_cur = (r_cnt == '0)
                    ? ((uw.seg == psg_pkg::SEG_RISE) ? lo_s : hi_s)
                    : r_lvl;
    assign ramp_nxt = ramp_cur +
                      ((uw.seg == psg_pkg::SEG_RISE) ? r_rdelta : r_fdelta);

    // ------------------------------------------------------------------
    // Sequencer: next step
    // ------------------------------------------------------------------
    always_comb begin
        n_step = r_step;
        unique case (uw.op)
            psg_pkg::UOP_WAIT_IN:  if (in_acc) n_step = uw.next;
            psg_pkg::UOP_DIV_LOAD: n_step = uw.next;
            psg_pkg::UOP_DIV_RUN:  if (r_div_cnt == CW'(1)) n_step = uw.next;
            psg_pkg::UOP_HOLD:     if (!hold_en || out_can) n_step = uw.next;
            psg_pkg::UOP_RAMP:     if (ramp_end) n_step = uw.next;
            default:               n_step = psg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: control decode
    logic                       div_load, div_run, emit, cnt_inc, cnt_clr;
    logic signed [AW-1:0]       emit_lvl;
    logic [psg_pkg::DUR_W-1:0]  emit_dur;
    logic [psg_pkg::MODE_W-1:0] emit_meas;
    logic                       emit_last;

    always_comb begin
        div_load  = 1'b0;
        div_run   = 1'b0;
        emit      = 1'b0;
        cnt_inc   = 1'b0;
        cnt_clr   = 1'b0;
        emit_lvl  = hold_lvl;
        emit_dur  = hold_dur;
        emit_meas = hold_meas;
        emit_last = !later;
        unique case (uw.op)
            psg_pkg::UOP_WAIT_IN:  cnt_clr  = 1'b1;
            psg_pkg::UOP_DIV_LOAD: div_load = 1'b1;
            psg_pkg::UOP_DIV_RUN:  div_run  = 1'b1;
            psg_pkg::UOP_HOLD:     emit     = hold_en && out_can;
            psg_pkg::UOP_RAMP: begin
                if (ramp_end) begin
                    cnt_clr = 1'b1;
                end else begin
                    emit    = out_can;
                    cnt_inc = out_can;
                end
                emit_lvl  = ramp_nxt;
                emit_dur  = psg_pkg::DUR_W'(1);
                emit_meas = tag;
                emit_last = !later && (r_cnt == ramp_steps - SW'(1));
            end
            default: cnt_clr = 1'b1;
        endcase
    end

    // Level out: value is non-negative, zero-extend then keep the low bits
    logic [AW+psg_pkg::LEVEL_W-1:0] lvl_wide;
    assign lvl_wide = {{psg_pkg::LEVEL_W{1'b0}}, emit_lvl};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= psg_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            if (cnt_clr)      r_cnt <= '0;
            else if (cnt_inc) r_cnt <= r_cnt + SW'(1);

            if (div_load)     r_div_cnt <= CW'(MW);
            else if (div_run) r_div_cnt <= r_div_cnt - CW'(1);

            if (emit)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_vlo   <= i_v_low;
            r_vhi   <= i_v_high;
            r_pre   <= i_pre_hold_us;
            r_post  <= i_post_hold_us;
            r_rise  <= (i_rise_steps > MAX_STEPS) ? MAX_STEPS : i_rise_steps;
            r_fall  <= (i_fall_steps > MAX_STEPS) ? MAX_STEPS : i_fall_steps;
            r_plat  <= i_plateau_us;
            r_wait  <= i_wait_us;
            r_stop  <= i_stop_us;
            r_mmode <= i_measure_mode;
        end

        if (div_load) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= ((uw.seg == psg_pkg::SEG_RISE) ? r_rise : r_fall) + SW'(1);
        end else if (div_run) begin
            r_quo <= quo_n;
            r_rem <= q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
            if (r_div_cnt == CW'(1)) begin
                // Fall steps are added, so the fall delta carries the opposite sign.
                if (uw.seg == psg_pkg::SEG_RISE) r_rdelta <= neg ? -q_s : q_s;
                else                             r_fdelta <= neg ? q_s : -q_s;
            end
        end

        if (cnt_inc) r_lvl <= ramp_nxt;

        if (emit) begin
            r_level <= lvl_wide[psg_pkg::LEVEL_W-1:0];
            r_dur   <= emit_dur;
            r_meas  <= emit_meas;
            r_last  <= emit_last;
        end
    end

    assign o_in_ready       = (uw.op == psg_pkg::UOP_WAIT_IN);
    assign o_out_valid      = r_out_valid;
    assign o_level          = r_level;
    assign o_duration_us    = r_dur;
    assign o_window_measure = r_meas;
    assign o_last           = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_acc, r_step == psg_pkg::ST_RDIV_LD)
    `ASSERT_IMPL(a_emit_only_in_window_steps, i_clk, i_rst_n, emit, r_step >= psg_pkg::ST_PRE)
    `ASSERT_IMPL(a_div_count_bound, i_clk, i_rst_n, div_run, (r_div_cnt != '0) && (r_div_cnt <= CW'(MW)))
    `ASSERT_IMPL(a_ramp_count_bound, i_clk, i_rst_n, uw.op == psg_pkg::UOP_RAMP, r_cnt <= ramp_steps)

endmodule

@@ tb/pulse_segment_generator_core_tb.sv @@
// Self-checking testbench for the pulse segment generator: directed and random pulses in, window lists checked.
module pulse_segment_generator_core_tb;

    localparam int MAX_STEPS      = 28;
    localparam int FRAC_BITS      = 8;
    localparam int NUM_RANDOM     = 410;
    localparam int IDLE_PCT       = 24;
    localparam int HOLD_OFF_LEN   = 400;   // long receiver stall, fills the block
    localparam int HOLD_OFF_AFTER = 100;   // pulses accepted before the stall starts
    localparam int CALM_FIRST     = 150;   // no idling on either side in this range
    localparam int CALM_LAST      = 250;
    localparam int DRAIN_CYCLES   = 200;   // > one pulse of sequencer time
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic K_RW  = psg_pkg::KIND_RW;
    localparam logic K_SMP = psg_pkg::KIND_SAMPLING;

    typedef struct packed {
        logic                         kind;
        logic [psg_pkg::V_W-1:0]      v_low;
        logic [psg_pkg::V_W-1:0]      v_high;
        logic [psg_pkg::DUR_W-1:0]    pre_hold_us;
        logic [psg_pkg::DUR_W-1:0]    post_hold_us;
        logic [psg_pkg::STEP_W-1:0]   rise_steps;
        logic [psg_pkg::STEP_W-1:0]   fall_steps;
        logic [psg_pkg::DUR_W-1:0]    plateau_us;
        logic [psg_pkg::DUR_W-1:0]    meas_wait_us;
        logic [psg_pkg::DUR_W-1:0]    meas_stop_us;
        logic [psg_pkg::MODE_W-1:0]   measure_mode;
    } t_pulse;

    typedef struct packed {
        logic [psg_pkg::LEVEL_W-1:0]  level;
        logic [psg_pkg::DUR_W-1:0]    duration_us;
        logic [psg_pkg::MODE_W-1:0]   window_measure;
        logic                         last;
    } t_window;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic   in_valid  = 1'b0;
    logic   out_ready = 1'b0;
    t_pulse drv_pulse = '0;

    logic                         in_ready;
    logic                         out_valid;
    logic [psg_pkg::LEVEL_W-1:0]  out_level;
    logic [psg_pkg::DUR_W-1:0]    out_duration_us;
    logic [psg_pkg::MODE_W-1:0]   out_window_measure;
    logic                         out_last;

    t_pulse  pending_pulses[$];
    t_window expected_windows[$];
    int      num_pulses;
    int      pulses_accepted = 0;
    int      err_count       = 0;
    int      stall_cycles    = 0;
    int      hold_left       = 0;
    logic    hold_done       = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pulse_segment_generator_core #(
        .MAX_RAMP_STEPS (MAX_STEPS),
        .FRACTION_BITS  (FRAC_BITS)
    ) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_kind           (drv_pulse.kind),
        .i_v_low          (drv_pulse.v_low),
        .i_v_high         (drv_pulse.v_high),
        .i_pre_hold_us    (drv_pulse.pre_hold_us),
        .i_post_hold_us   (drv_pulse.post_hold_us),
        .i_rise_steps     (drv_pulse.rise_steps),
        .i_fall_steps     (drv_pulse.fall_steps),
        .i_plateau_us     (drv_pulse.plateau_us),
        .i_wait_us        (drv_pulse.meas_wait_us),
        .i_stop_us        (drv_pulse.meas_stop_us),
        .i_measure_mode   (drv_pulse.measure_mode),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_level          (out_level),
        .o_duration_us    (out_duration_us),
        .o_window_measure (out_window_measure),
        .o_last           (out_last)
    );

    // Idle rate shared by both sides; a calm stretch in the middle of the run.
    function automatic int idle_pct();
        return (pulses_accepted >= CALM_FIRST && pulses_accepted < CALM_LAST) ? 0 : IDLE_PCT;
    endfunction

    function automatic t_window mk_window(input int lvl, input logic [psg_pkg::DUR_W-1:0] dur,
                                          input logic [psg_pkg::MODE_W-1:0] mode);
        t_window w;
        w.level          = psg_pkg::LEVEL_W'(lvl);
        w.duration_us    = dur;
        w.window_measure = mode;
        w.last           = 1'b0;
        return w;
    endfunction

    // Window list of one pulse, appended to the expected windows.
    function automatic void predict_windows(input t_pulse p);
        t_window       wins[$];
        int            lo, hi, n_rise, n_fall, rise_delta, fall_delta, lvl;
        logic          sampling;
        logic [psg_pkg::MODE_W-1:0] tag;
        logic [psg_pkg::MODE_W-1:0] plat_mode;
        sampling   = (p.kind == psg_pkg::KIND_SAMPLING);
        tag        = sampling ? psg_pkg::MODE_SAMPLING : psg_pkg::MODE_NONE;
        plat_mode  = sampling ? psg_pkg::MODE_SAMPLING : p.measure_mode;
        lo         = int'(p.v_low) << FRAC_BITS;
        hi         = int'(p.v_high) << FRAC_BITS;
        n_rise     = (p.rise_steps > MAX_STEPS) ? MAX_STEPS : int'(p.rise_steps);
        n_fall     = (p.fall_steps > MAX_STEPS) ? MAX_STEPS : int'(p.fall_steps);
        // signed int division truncates toward zero
        rise_delta = (hi - lo) / (n_rise + 1);
        fall_delta = (hi - lo) / (n_fall + 1);

        if (p.pre_hold_us != 0) wins.push_back(mk_window(lo, p.pre_hold_us, tag));
        lvl = lo;
        for (int k = 0; k < n_rise; k++) begin
            lvl += rise_delta;
            wins.push_back(mk_window(lvl, psg_pkg::DUR_W'(1), tag));
        end
        if (!sampling && p.meas_wait_us != 0)
            wins.push_back(mk_window(hi, p.meas_wait_us, psg_pkg::MODE_NONE));
        if (p.plateau_us != 0)
            wins.push_back(mk_window(hi, p.plateau_us, plat_mode));
        if (!sampling && p.meas_stop_us != 0)
            wins.push_back(mk_window(hi, p.meas_stop_us, psg_pkg::MODE_NONE));
        lvl = hi;
        for (int k = 0; k < n_fall; k++) begin
            lvl -= fall_delta;
            wins.push_back(mk_window(lvl, psg_pkg::DUR_W'(1), tag));
        end
        if (p.post_hold_us != 0) wins.push_back(mk_window(lo, p.post_hold_us, tag));

        if (wins.size() > 0) wins[wins.size()-1].last = 1'b1;
        foreach (wins[i]) expected_windows.push_back(wins[i]);
    endfunction

    function automatic t_pulse mk_pulse(input logic kind, input int vlo, input int vhi,
                                        input int pre, input int post, input int rise,
                                        input int fall, input int plat, input int mwait,
                                        input int mstop, input int mode);
        t_pulse p;
        p.kind         = kind;
        p.v_low        = psg_pkg::V_W'(vlo);
        p.v_high       = psg_pkg::V_W'(vhi);
        p.pre_hold_us  = psg_pkg::DUR_W'(pre);
        p.post_hold_us = psg_pkg::DUR_W'(post);
        p.rise_steps   = psg_pkg::STEP_W'(rise);
        p.fall_steps   = psg_pkg::STEP_W'(fall);
        p.plateau_us   = psg_pkg::DUR_W'(plat);
        p.meas_wait_us = psg_pkg::DUR_W'(mwait);
        p.meas_stop_us = psg_pkg::DUR_W'(mstop);
        p.measure_mode = psg_pkg::MODE_W'(mode);
        return p;
    endfunction

    // Mix of skipped, full-scale, short and arbitrary durations.
    function automatic int rand_dur();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return 0;
        if (pick == 3) return 16'hFFFF;
        if (pick < 6) return $urandom_range(1, 20);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    function automatic int rand_code();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 0;
        if (pick == 1) return 1023;
        return $urandom_range(0, 1023);
    endfunction

    function automatic int rand_steps();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick == 1) return MAX_STEPS;
        if (pick < 4) return $urandom_range(0, 31);    // includes the saturating counts
        return $urandom_range(0, 8);
    endfunction

    function automatic t_pulse rand_pulse();
        t_pulse p;
        int     vlo;
        vlo = rand_code();
        p = mk_pulse(1'($urandom_range(0, 1)), vlo,
                     ($urandom_range(0, 9) == 0) ? vlo : rand_code(),
                     rand_dur(), rand_dur(), rand_steps(), rand_steps(), rand_dur(),
                     rand_dur(), rand_dur(), $urandom_range(0, 3));
        return p;
    endfunction

    // Stimulus, reset and end of run.
    initial begin
        // nothing to emit, both kinds
        pending_pulses.push_back(mk_pulse(K_RW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pulses.push_back(mk_pulse(K_SMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // sampling ignores wait, stop and mode: still nothing to emit
        pending_pulses.push_back(mk_pulse(K_SMP, 5, 9, 0, 0, 0, 0, 0, 7, 7, 3));
        // full scale, step counts above the limit saturate
        pending_pulses.push_back(mk_pulse(K_RW, 0, 1023, 16'hFFFF, 16'hFFFF, 31, 31,
                                          16'hFFFF, 16'hFFFF, 16'hFFFF, 3));
        pending_pulses.push_back(mk_pulse(K_SMP, 0, 1023, 16'hFFFF, 16'hFFFF, 31, 31,
                                          16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        // high below low: falling rise, rising fall
        pending_pulses.push_back(mk_pulse(K_RW, 1023, 0, 3, 4, 28, 28, 5, 6, 7, 2));
        pending_pulses.push_back(mk_pulse(K_SMP, 700, 3, 0, 0, 29, 30, 1, 0, 0, 0));
        // equal levels, zero deltas
        pending_pulses.push_back(mk_pulse(K_RW, 512, 512, 1, 1, 5, 5, 1, 1, 1, 1));
        // plateau only, every measurement mode
        for (int m = 0; m < 4; m++)
            pending_pulses.push_back(mk_pulse(K_RW, 10, 900, 0, 0, 0, 0, 100, 0, 0, m));
        // single windows
        pending_pulses.push_back(mk_pulse(K_RW, 10, 900, 25, 0, 0, 0, 0, 0, 0, 0));
        pending_pulses.push_back(mk_pulse(K_RW, 10, 900, 0, 25, 0, 0, 0, 0, 0, 0));
        pending_pulses.push_back(mk_pulse(K_RW, 10, 900, 0, 0, 0, 0, 0, 25, 0, 0));
        pending_pulses.push_back(mk_pulse(K_RW, 10, 900, 0, 0, 0, 0, 0, 0, 25, 0));
        // ramps only, with short step counts
        pending_pulses.push_back(mk_pulse(K_RW, 1, 1000, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_pulses.push_back(mk_pulse(K_SMP, 1, 1000, 0, 0, 0, 1, 0, 0, 0, 0));
        pending_pulses.push_back(mk_pulse(K_RW, 1000, 1, 0, 0, 2, 3, 0, 0, 0, 0));
        // alternating bit patterns
        pending_pulses.push_back(mk_pulse(K_RW, 10'h155, 10'h2AA, 16'h5555, 16'hAAAA,
                                          5'h15, 5'h0A, 16'hAAAA, 16'h5555, 16'hAAAA, 1));
        pending_pulses.push_back(mk_pulse(K_RW, 10'h2AA, 10'h155, 16'hAAAA, 16'h5555,
                                          5'h0A, 5'h15, 16'h5555, 16'hAAAA, 16'h5555, 2));
        // back-to-back short pulses
        pending_pulses.push_back(mk_pulse(K_RW, 0, 1, 1, 1, 0, 0, 1, 1, 1, 3));
        pending_pulses.push_back(mk_pulse(K_SMP, 1023, 1022, 1, 1, 0, 0, 1, 1, 1, 3));

        for (int i = 0; i < NUM_RANDOM; i++) pending_pulses.push_back(rand_pulse());
        num_pulses = pending_pulses.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pulses_accepted < num_pulses) @(posedge clk);
        while (expected_windows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Pulse driver: valid held with a stable payload until taken.
    always @(posedge clk) begin : pulse_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_windows(drv_pulse);
                pulses_accepted <= pulses_accepted + 1;
            end
            if (!in_valid || in_ready) begin
                if (pending_pulses.size() > 0 && $urandom_range(0, 99) >= idle_pct()) begin
                    drv_pulse <= pending_pulses.pop_front();
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Window receiver: random back-pressure plus one long hold-off.
    always @(posedge clk) begin : window_receiver
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (!hold_done && pulses_accepted >= HOLD_OFF_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_LEN;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= idle_pct());
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: window %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    // Window monitor: each taken window against the oldest expected one.
    always @(posedge clk) begin : window_monitor
        t_window want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_windows.size() == 0) begin
                $display("%0t: unexpected window, expected none, actual level %0d dur %0d",
                         $time, out_level, out_duration_us);
                $display("%0t: unexpected window, actual mode %0d last %0d",
                         $time, out_window_measure, out_last);
                err_count++;
            end else begin
                want = expected_windows.pop_front();
                check_field("level", want.level, out_level);
                check_field("duration_us", want.duration_us, out_duration_us);
                check_field("window_measure", want.window_measure, out_window_measure);
                check_field("last", want.last, out_last);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
